// ----- sv/h263dp_pkg.sv -----
// Shared types and constants for the RFC 2190 H.263 depacketizer.
`default_nettype none

package h263dp_pkg;

  // Kind of request on the input stream.
  typedef enum logic {
    OP_PAYLOAD = 1'b0,
    OP_FLUSH   = 1'b1
  } op_e;

  typedef logic [7:0] byte_t;
  typedef logic [3:0] hdr_cnt_t;
  typedef logic [2:0] skip_t;

  // Payload header lengths for modes A, B and C.
  localparam hdr_cnt_t HdrLenModeA = 4'd4;
  localparam hdr_cnt_t HdrLenModeB = 4'd8;
  localparam hdr_cnt_t HdrLenModeC = 4'd12;

  localparam byte_t ByteMaskAll = 8'hff;

endpackage

`default_nettype wire

// ----- sv/rfc2190_h263_depacketizer.sv -----
// Top level of the RFC 2190 H.263 payload depacketizer.
// A result reaches the single output register in the cycle after its request is accepted.
// Throughput: one request per cycle if not stalled; the register refills in the cycle it drains.
// Each byte is parsed by mask-and-merge logic between the input handshake and the output register.
// Reset: asynchronous, active low; clears header parsing state, the held byte and the output valid.
`default_nettype none

module rfc2190_h263_depacketizer (
  input  wire logic                 clk_i,
  input  wire logic                 rst_ni,
  // Input stream.
  input  wire logic                 s_axis_tvalid_i,
  output logic                      s_axis_tready_o,
  input  wire h263dp_pkg::byte_t    s_axis_tdata_i,   // [7:0] in_byte
  input  wire logic [1:0]           s_axis_tuser_i,   // [0] operation, [1] first_of_packet
  input  wire logic                 s_axis_tlast_i,   // last_of_packet
  // Output stream.
  output logic                      m_axis_tvalid_o,
  input  wire logic                 m_axis_tready_i,
  output h263dp_pkg::byte_t         m_axis_tdata_o,   // [7:0] out_byte
  output logic                      m_axis_tlast_o    // end_of_frame
);

  import h263dp_pkg::*;

  // Parsing state.
  hdr_cnt_t hdr_cnt_q, hdr_cnt_d;
  hdr_cnt_t hdr_len_q, hdr_len_d;
  skip_t    sbit_q, sbit_d;
  skip_t    ebit_q, ebit_d;
  byte_t    held_q, held_d;
  logic     held_valid_q, held_valid_d;
  logic     first_pend_q, first_pend_d;

  // Output register.
  logic     out_valid_q;
  byte_t    out_byte_q, out_byte_d;
  logic     out_eof_q, out_eof_d;
  logic     res_valid;

  logic     in_acc;
  op_e      op;
  logic     first_mark;
  byte_t    data_masked;

  assign op         = op_e'(s_axis_tuser_i[0]);
  assign first_mark = s_axis_tuser_i[1];

  // A new request is taken whenever the output register is empty or drains now.
  assign s_axis_tready_o = !out_valid_q || m_axis_tready_i;
  assign in_acc          = s_axis_tvalid_i && s_axis_tready_o;

  // The last data byte of a packet keeps only its top 8-EBIT bits.
  assign data_masked = s_axis_tlast_i ? (s_axis_tdata_i & byte_t'(ByteMaskAll << ebit_q))
                                      : s_axis_tdata_i;

  // Per-request parse, merge and emit decision.
  always_comb begin
    hdr_cnt_d    = hdr_cnt_q;
    hdr_len_d    = hdr_len_q;
    sbit_d       = sbit_q;
    ebit_d       = ebit_q;
    held_d       = held_q;
    held_valid_d = held_valid_q;
    first_pend_d = first_pend_q;
    res_valid    = 1'b0;
    out_byte_d   = held_q;
    out_eof_d    = 1'b0;
    case (op)
      OP_FLUSH: begin
        first_pend_d = 1'b1;
        if (held_valid_q) begin
          held_valid_d = 1'b0;
          res_valid    = 1'b1;
          out_eof_d    = 1'b1;
        end
      end
      OP_PAYLOAD: begin
        if (first_mark || (hdr_cnt_q == '0)) begin
          // First header byte carries F, P, SBIT and EBIT.
          sbit_d       = s_axis_tdata_i[5:3];
          ebit_d       = s_axis_tdata_i[2:0];
          hdr_len_d    = s_axis_tdata_i[7] ? (s_axis_tdata_i[6] ? HdrLenModeC : HdrLenModeB)
                                           : HdrLenModeA;
          hdr_cnt_d    = hdr_cnt_t'(1);
          first_pend_d = 1'b1;
        end else if (hdr_cnt_q < hdr_len_q) begin
          hdr_cnt_d = hdr_cnt_q + hdr_cnt_t'(1);
        end else begin
          first_pend_d = 1'b0;
          if (first_pend_q && (sbit_q != '0) && held_valid_q) begin
            // Partial first byte completes the byte already held.
            held_d = held_q | (data_masked & byte_t'(ByteMaskAll >> sbit_q));
          end else begin
            held_d       = data_masked;
            held_valid_d = 1'b1;
            res_valid    = held_valid_q;
          end
        end
      end
      default: begin
        res_valid = 1'b0;
      end
    endcase
  end

  // State registers, updated on each accepted request.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      hdr_cnt_q    <= '0;
      hdr_len_q    <= HdrLenModeA;
      sbit_q       <= '0;
      ebit_q       <= '0;
      held_q       <= '0;
      held_valid_q <= 1'b0;
      first_pend_q <= 1'b1;
    end else if (in_acc) begin
      hdr_cnt_q    <= hdr_cnt_d;
      hdr_len_q    <= hdr_len_d;
      sbit_q       <= sbit_d;
      ebit_q       <= ebit_d;
      held_q       <= held_d;
      held_valid_q <= held_valid_d;
      first_pend_q <= first_pend_d;
    end
  end

  // Output valid flag.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (s_axis_tready_o) begin
      out_valid_q <= in_acc && res_valid;
    end
  end

  // Output payload, loaded only with a new result.
  always_ff @(posedge clk_i) begin
    if (in_acc && res_valid) begin
      out_byte_q <= out_byte_d;
      out_eof_q  <= out_eof_d;
    end
  end

  assign m_axis_tvalid_o = out_valid_q;
  assign m_axis_tdata_o  = out_byte_q;
  assign m_axis_tlast_o  = out_eof_q;

  // The header counter never runs past the header length of its packet.
  assert property (@(posedge clk_i) disable iff (!rst_ni) hdr_cnt_q <= hdr_len_q)
    else $error("header count beyond header length");

  // The header length is always one of the three mode lengths.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (hdr_len_q == HdrLenModeA) || (hdr_len_q == HdrLenModeB) || (hdr_len_q == HdrLenModeC))
    else $error("illegal header length");

  // An accepted flush always leaves nothing held and the next data byte marked first.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_acc && (op == OP_FLUSH)) |=> (!held_valid_q && first_pend_q))
    else $error("flush did not clear the held byte");

  // A frame end is only signaled when the output register holds a flush result.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_acc && res_valid && (op == OP_PAYLOAD)) |=> (out_valid_q && !out_eof_q))
    else $error("data byte result carries an end of frame");

endmodule

`default_nettype wire
